FILE: hw/rtl/lmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmsd_pkg;

  // Panel geometry and latch sequence length
  localparam int ROW_PIXELS  = 32;
  localparam int ROW_COUNT   = 8;
  localparam int LATCH_TICKS = 3;

  localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W   = $clog2(ROW_PIXELS + 1);
  localparam int LCNT_W  = $clog2(LATCH_TICKS + 1);
  localparam int STORE_DEPTH = ROW_COUNT * ROW_PIXELS;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int COLOUR_W = 3;
  localparam int PIN_ADDR_W = 3;
  localparam int LATCH_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_KEEP  = 2'd1;
  localparam logic [LATCH_W-1:0] LATCH_START_RESET = 8'd7;
  localparam logic [LATCH_W-1:0] LATCH_KEEP_RESET  = 8'hFF;

  // Item kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_PRIME,
    ST_SHIFT,
    ST_LATCH
  } lmsd_state_t;

  // Pin state after one item, plus whether the colour comes from the store read
  typedef struct packed {
    logic                  clock_pin;
    logic [PIN_ADDR_W-1:0] address_pins;
    logic [LATCH_W-1:0]    latch_pins;
    logic                  load;
  } lmsd_pins_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lmsd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lmsd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] write_row;
  logic [4:0] write_column;
  logic [2:0] write_colour;

  modport source(output valid, func, write_row, write_column, write_colour, input ready);
  modport sink(input valid, func, write_row, write_column, write_colour, output ready);
endinterface

interface lmsd_out_if;
  logic       valid;
  logic       ready;
  logic       clock_pin;
  logic [2:0] colour_pins;
  logic [2:0] address_pins;
  logic [7:0] latch_pins;

  modport source(output valid, clock_pin, colour_pins, address_pins, latch_pins, input ready);
  modport sink(input valid, clock_pin, colour_pins, address_pins, latch_pins, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/led_matrix_scan_driver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                             Transfer when
// in_ch    in   func, write_row, write_column, write_colour         valid && ready
// out_ch   out  clock_pin, colour_pins, address_pins, latch_pins    valid && ready
// cfg      in   cfg_index, cfg_data                                  cfg_we
//
// One item per cycle sustained while the output is not stalled; each result passes through
// the store read stage, then the output register.
// The frame store is a single RAM with a registered read; at most one read or one write per item.
// rst (synchronous) clears the sequencer to its pre-scan state; the store holds no reset.
// A stalled output holds the pipe; input ready drops only when both stages are full.

module led_matrix_scan_driver_unit
  import lmsd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  lmsd_in_if.sink                    in_ch,
  lmsd_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [LATCH_W-1:0] latch_start_pattern;
  logic [LATCH_W-1:0] latch_keep_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_start_pattern <= LATCH_START_RESET;
      latch_keep_mask     <= LATCH_KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LATCH_START: latch_start_pattern <= cfg_data;
        REG_LATCH_KEEP:  latch_keep_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                take;
  logic                ready;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COLOUR_W-1:0] wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [COLOUR_W-1:0] rd_data;
  lmsd_pins_t          pins;

  assign in_ch.ready = ready;
  assign take        = in_ch.valid && ready;

  // Scan sequencer: row/column/clock/latch state, issues the store access
  lmsd_seq u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .take                (take),
    .func                (in_ch.func),
    .write_row           (in_ch.write_row),
    .write_column        (in_ch.write_column),
    .write_colour        (in_ch.write_colour),
    .latch_start_pattern (latch_start_pattern),
    .latch_keep_mask     (latch_keep_mask),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .rd_en               (rd_en),
    .rd_addr             (rd_addr),
    .pins                (pins)
  );

  // Frame store, one entry per pixel, row-major
  lmsd_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read-data stage and output register
  lmsd_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .pins    (pins),
    .rd_data (rd_data),
    .ready   (ready),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lmsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lmsd_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_seq
  import lmsd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic                  func,
  input  wire logic [2:0]            write_row,
  input  wire logic [4:0]            write_column,
  input  wire logic [COLOUR_W-1:0]   write_colour,
  input  wire logic [LATCH_W-1:0]    latch_start_pattern,
  input  wire logic [LATCH_W-1:0]    latch_keep_mask,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [COLOUR_W-1:0]        wr_data,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  output lmsd_pins_t                 pins
);

  lmsd_state_t state, state_next;

  logic [ROW_W-1:0]      row, row_next;
  logic [COL_W-1:0]      col, col_next;
  logic                  clk_lvl, clk_lvl_next;
  logic [LATCH_W-1:0]    latch_shift, latch_shift_next;
  logic [LCNT_W-1:0]     lcount, lcount_next;
  logic [PIN_ADDR_W-1:0] pin_address, pin_address_next;
  logic [LATCH_W-1:0]    pin_latch, pin_latch_next;

  logic             tick;
  logic             row_end;
  logic             latch_last;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] rd_row;
  logic [COL_W-1:0] rd_col;
  logic             load;

  assign tick       = take && (func == FUNC_TICK);
  assign row_end    = (col == COL_W'(ROW_PIXELS));
  assign latch_last = (lcount == LCNT_W'(LATCH_TICKS - 1));
  assign row_inc    = (row == ROW_W'(ROW_COUNT - 1)) ? '0 : row + ROW_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    if (tick) begin
      case (state)
        ST_PRIME: state_next = ST_SHIFT;
        ST_SHIFT: begin
          if (clk_lvl && row_end) begin
            state_next = ST_LATCH;
          end
        end
        ST_LATCH: begin
          if (latch_last) begin
            state_next = ST_SHIFT;
          end
        end
        default: state_next = ST_PRIME;
      endcase
    end
  end

  // Datapath updates and store read
  always_comb begin
    row_next         = row;
    col_next         = col;
    clk_lvl_next     = clk_lvl;
    latch_shift_next = latch_shift;
    lcount_next      = lcount;
    pin_address_next = pin_address;
    pin_latch_next   = pin_latch;
    load             = 1'b0;
    rd_row           = row;
    rd_col           = col;
    if (tick) begin
      case (state)
        ST_PRIME: begin
          // first tick: address and pixel 0 go out, and the clock rises with them
          load             = 1'b1;
          col_next         = col + COL_W'(1);
          clk_lvl_next     = ~clk_lvl;
          pin_address_next = PIN_ADDR_W'(row);
        end
        ST_SHIFT: begin
          clk_lvl_next = ~clk_lvl;
          if (clk_lvl) begin
            load = 1'b1;
            if (row_end) begin
              row_next = row_inc;
              rd_row   = row_inc;
              rd_col   = '0;
              col_next = COL_W'(1);
            end else begin
              col_next = col + COL_W'(1);
            end
          end
        end
        ST_LATCH: begin
          pin_latch_next = latch_shift;
          if (latch_last) begin
            lcount_next      = '0;
            latch_shift_next = latch_start_pattern;
            pin_address_next = PIN_ADDR_W'(row);
          end else begin
            lcount_next      = lcount + LCNT_W'(1);
            latch_shift_next = (latch_shift >> 1) & latch_keep_mask;
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_en   = load;
  assign rd_addr = ADDR_W'(32'(rd_row) * ROW_PIXELS + 32'(rd_col));

  assign wr_en   = take && (func == FUNC_WRITE) && (32'(write_row) < ROW_COUNT)
                   && (32'(write_column) < ROW_PIXELS);
  assign wr_addr = ADDR_W'(32'(write_row) * ROW_PIXELS + 32'(write_column));
  assign wr_data = write_colour;

  assign pins.clock_pin    = clk_lvl_next;
  assign pins.address_pins = pin_address_next;
  assign pins.latch_pins   = pin_latch_next;
  assign pins.load         = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_PRIME;
      row         <= '0;
      col         <= '0;
      clk_lvl     <= 1'b0;
      latch_shift <= LATCH_START_RESET;
      lcount      <= '0;
      pin_address <= '0;
      pin_latch   <= '0;
    end else begin
      state       <= state_next;
      row         <= row_next;
      col         <= col_next;
      clk_lvl     <= clk_lvl_next;
      latch_shift <= latch_shift_next;
      lcount      <= lcount_next;
      pin_address <= pin_address_next;
      pin_latch   <= pin_latch_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lmsd_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module lmsd_pipe
  import lmsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire lmsd_pins_t          pins,
  input  wire logic [COLOUR_W-1:0] rd_data,
  output logic                     ready,
  lmsd_out_if.source               out_ch
);

  logic                  s1_valid;
  lmsd_pins_t            s1_pins;
  logic                  s1_adv;
  logic [COLOUR_W-1:0]   colour;
  logic [COLOUR_W-1:0]   colour_now;

  logic                  out_valid;
  logic                  out_clock;
  logic [COLOUR_W-1:0]   out_colour;
  logic [PIN_ADDR_W-1:0] out_address;
  logic [LATCH_W-1:0]    out_latch;

  assign s1_adv     = s1_valid && (!out_valid || out_ch.ready);
  assign ready      = !s1_valid || s1_adv;
  // store data is held in the RAM read register until this item moves on
  assign colour_now = s1_pins.load ? rd_data : colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      colour    <= '0;
    end else begin
      if (ready) begin
        s1_valid <= take;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        colour    <= colour_now;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && take) begin
      s1_pins <= pins;
    end
    if (s1_adv) begin
      out_clock   <= s1_pins.clock_pin;
      out_colour  <= colour_now;
      out_address <= s1_pins.address_pins;
      out_latch   <= s1_pins.latch_pins;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.clock_pin    = out_clock;
  assign out_ch.colour_pins  = out_colour;
  assign out_ch.address_pins = out_address;
  assign out_ch.latch_pins   = out_latch;

endmodule

`default_nettype wire
